// ===== sv/difficulty_retarget_compact_assert.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the compact retarget block
// Clocked property checks with and without reset gating.
// -----------------------------------------------------------------------------
`ifndef DIFFICULTY_RETARGET_COMPACT_ASSERT_SVH
`define DIFFICULTY_RETARGET_COMPACT_ASSERT_SVH

// check gated off while reset is asserted
`define DRC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that holds through reset as well
`define DRC_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/drc_pkg.sv =====
// -----------------------------------------------------------------------------
// drc_pkg
// Shared types and register codes of the compact retarget block.
// -----------------------------------------------------------------------------
package drc_pkg;

  localparam int unsigned IdxW = 3;

  localparam logic [IdxW-1:0] REG_NO_RETARGET = 3'd0;
  localparam logic [IdxW-1:0] REG_AVG_SPAN    = 3'd1;
  localparam logic [IdxW-1:0] REG_ADJ_UP      = 3'd2;
  localparam logic [IdxW-1:0] REG_ADJ_DOWN    = 3'd3;
  localparam logic [IdxW-1:0] REG_LIMIT3      = 3'd4;
  localparam logic [IdxW-1:0] REG_LIMIT2      = 3'd5;
  localparam logic [IdxW-1:0] REG_LIMIT1      = 3'd6;
  localparam logic [IdxW-1:0] REG_LIMIT0      = 3'd7;

  localparam logic [30:0] AVG_SPAN_RST = 31'd3000;
  localparam logic [6:0]  ADJ_UP_RST   = 7'd4;
  localparam logic [9:0]  ADJ_DOWN_RST = 10'd16;
  localparam logic [63:0] LIMIT3_RST   = 64'h0000_0FFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT_RST    = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] PERCENT = 8'd100;

  // bypass flag and original word riding along with each transaction
  typedef struct packed {
    logic        bypass;
    logic [31:0] prev;
  } side_t;

endpackage

// ===== sv/drc_mul_cell.sv =====
// -----------------------------------------------------------------------------
// drc_mul_cell
// One shift-add step of the target by span multiply.
// -----------------------------------------------------------------------------
module drc_mul_cell #(
  parameter int unsigned W = 256,
  parameter int unsigned K = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  drc_pkg::side_t   side_i,
  input  logic [W-1:0]     v_i,
  input  logic [31:0]      s_i,
  input  logic [W-1:0]     acc_i,
  output logic             valid_o,
  output drc_pkg::side_t   side_o,
  output logic [W-1:0]     v_o,
  output logic [31:0]      s_o,
  output logic [W-1:0]     acc_o
);

  logic [W-1:0] acc_d;

  assign acc_d = acc_i + (s_i[K] ? (v_i << K) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      v_o    <= v_i;
      s_o    <= s_i;
      acc_o  <= acc_d;
    end
  end

endmodule

// ===== sv/drc_div_cell.sv =====
// -----------------------------------------------------------------------------
// drc_div_cell
// One restoring step of the divide by the averaging timespan.
// -----------------------------------------------------------------------------
module drc_div_cell #(
  parameter int unsigned W = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [30:0]      d_i,
  input  logic             valid_i,
  input  drc_pkg::side_t   side_i,
  input  logic [W-1:0]     num_i,
  input  logic [30:0]      rem_i,
  output logic             valid_o,
  output drc_pkg::side_t   side_o,
  output logic [W-1:0]     num_o,
  output logic [30:0]      rem_o
);

  logic [31:0] r;
  logic [31:0] diff;
  logic        ge;

  assign r    = {rem_i, num_i[W-1]};
  assign ge   = r >= {1'b0, d_i};
  assign diff = r - {1'b0, d_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      num_o  <= {num_i[W-2:0], ge};
      rem_o  <= ge ? diff[30:0] : r[30:0];
    end
  end

endmodule

// ===== sv/drc_bounds.sv =====
// -----------------------------------------------------------------------------
// drc_bounds
// Divide by 100 of the span bounds after a configuration change, by
// reciprocal multiplication over two halves of the product.
// -----------------------------------------------------------------------------
module drc_bounds (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_hit_i,
  input  logic [30:0]        avg_i,
  input  logic [6:0]         up_i,
  input  logic [9:0]         down_i,
  output logic               busy_o,
  output logic signed [63:0] lo_o,
  output logic signed [63:0] hi_o
);

  localparam int unsigned NumW  = 42;
  localparam int unsigned HalfW = 21;
  // floor(x / 100) = (x * Recip) >> 35 for any x below 2^28
  localparam logic [28:0] Recip = 29'd343597384;

  logic               load_q;
  logic               busy_q;
  logic               ph_q;
  logic               neg_q;
  logic [NumW-1:0]    lo_q, hi_q;
  logic [27:0]        curl_q, curh_q;

  logic signed [7:0]  up_fac;
  logic [10:0]        dn_fac;
  logic signed [39:0] lo_prod;
  logic [39:0]        lo_mag;
  logic [41:0]        hi_prod;
  logic [27:0]        nl, nh;
  logic [56:0]        prod_l, prod_h;
  logic [21:0]        ql, qh;
  logic [6:0]         rl, rh;

  assign up_fac  = $signed(drc_pkg::PERCENT) - $signed({1'b0, up_i});
  assign dn_fac  = {3'b0, drc_pkg::PERCENT} + {1'b0, down_i};
  assign lo_prod = $signed({9'b0, avg_i}) * 40'(up_fac);
  assign lo_mag  = lo_prod[39] ? 40'(-lo_prod) : lo_prod;
  assign hi_prod = {11'b0, avg_i} * {31'b0, dn_fac};

  assign nl     = ph_q ? curl_q : {7'b0, lo_q[NumW-1:HalfW]};
  assign nh     = ph_q ? curh_q : {7'b0, hi_q[NumW-1:HalfW]};
  assign prod_l = {29'b0, nl} * {28'b0, Recip};
  assign prod_h = {29'b0, nh} * {28'b0, Recip};
  assign ql     = prod_l[56:35];
  assign qh     = prod_h[56:35];
  assign rl     = nl[6:0] - 7'(ql[6:0] * 7'(drc_pkg::PERCENT));
  assign rh     = nh[6:0] - 7'(qh[6:0] * 7'(drc_pkg::PERCENT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      neg_q  <= 1'b0;
      lo_q   <= 42'd2880;
      hi_q   <= 42'd3480;
      curl_q <= '0;
      curh_q <= '0;
    end else begin
      load_q <= cfg_hit_i;
      if (load_q) begin
        busy_q <= 1'b1;
        ph_q   <= 1'b0;
        neg_q  <= lo_prod[39];
        lo_q   <= {2'b0, lo_mag};
        hi_q   <= hi_prod;
      end else if (busy_q) begin
        if (!ph_q) begin
          lo_q[NumW-1:HalfW] <= ql[HalfW-1:0];
          hi_q[NumW-1:HalfW] <= qh[HalfW-1:0];
          curl_q             <= {rl, lo_q[HalfW-1:0]};
          curh_q             <= {rh, hi_q[HalfW-1:0]};
          ph_q               <= 1'b1;
        end else begin
          lo_q[HalfW-1:0] <= ql[HalfW-1:0];
          hi_q[HalfW-1:0] <= qh[HalfW-1:0];
          ph_q            <= 1'b0;
          busy_q          <= 1'b0;
        end
      end
    end
  end

  assign busy_o = load_q | busy_q;
  assign lo_o   = neg_q ? -$signed({22'b0, lo_q}) : $signed({22'b0, lo_q});
  assign hi_o   = $signed({22'b0, hi_q});

endmodule

// ===== sv/difficulty_retarget_compact.sv =====
// -----------------------------------------------------------------------------
// difficulty_retarget_compact
// Compact target retarget: clamp span, decode, multiply, divide, cap, encode.
// -----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: prev_compact[31:0], measured_span[95:32]
// m_axis    out  tdata: next_compact[31:0]
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// Stages: input, decode, 32 multiply cells, one divide cell per target bit,
// cap and output register. One transaction enters per cycle while the cell
// chain advances and no bound computation runs; the chain advances whenever
// the output register is empty or taken. A write to the timespan or adjust
// registers starts a bound computation (load, high half, low half); no input
// is accepted meanwhile. Reset clears valids and restores register defaults.
// -----------------------------------------------------------------------------
`include "difficulty_retarget_compact_assert.svh"

module difficulty_retarget_compact #(
  parameter int unsigned TARGET_WIDTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // prev_compact, measured_span
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // next_compact
  input  logic        cfg_we_i,
  input  logic [drc_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned W  = TARGET_WIDTH;
  localparam int unsigned NB = (W + 7) / 8;
  localparam int unsigned PW = NB * 8;

  logic        no_ret_q;
  logic [30:0] avg_q;
  logic [6:0]  up_q;
  logic [9:0]  down_q;
  logic [63:0] lim3_q, lim2_q, lim1_q, lim0_q;

  logic               busy;
  logic signed [63:0] lo_b, hi_b;
  logic               cfg_hit;
  logic               en;
  logic               accept;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == drc_pkg::REG_AVG_SPAN ||
                   cfg_idx_i == drc_pkg::REG_ADJ_UP || cfg_idx_i == drc_pkg::REG_ADJ_DOWN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_ret_q <= 1'b0;
      avg_q    <= drc_pkg::AVG_SPAN_RST;
      up_q     <= drc_pkg::ADJ_UP_RST;
      down_q   <= drc_pkg::ADJ_DOWN_RST;
      lim3_q   <= drc_pkg::LIMIT3_RST;
      lim2_q   <= drc_pkg::LIMIT_RST;
      lim1_q   <= drc_pkg::LIMIT_RST;
      lim0_q   <= drc_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        drc_pkg::REG_NO_RETARGET: no_ret_q <= cfg_data_i[0];
        drc_pkg::REG_AVG_SPAN:    avg_q    <= cfg_data_i[30:0];
        drc_pkg::REG_ADJ_UP:      up_q     <= cfg_data_i[6:0];
        drc_pkg::REG_ADJ_DOWN:    down_q   <= cfg_data_i[9:0];
        drc_pkg::REG_LIMIT3:      lim3_q   <= cfg_data_i;
        drc_pkg::REG_LIMIT2:      lim2_q   <= cfg_data_i;
        drc_pkg::REG_LIMIT1:      lim1_q   <= cfg_data_i;
        drc_pkg::REG_LIMIT0:      lim0_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  drc_bounds u_bounds (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_hit_i (cfg_hit),
    .avg_i     (avg_q),
    .up_i      (up_q),
    .down_i    (down_q),
    .busy_o    (busy),
    .lo_o      (lo_b),
    .hi_o      (hi_b)
  );

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // input register
  logic               in_valid_q;
  drc_pkg::side_t     in_side_q;
  logic signed [63:0] in_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_side_q.bypass <= no_ret_q;
      in_side_q.prev   <= s_axis_tdata[31:0];
      in_span_q        <= $signed(s_axis_tdata[95:32]);
    end
  end

  // clamp and decode
  logic signed [63:0] span_c;
  logic [7:0]         dsize;
  logic [31:0]        mant;
  logic [10:0]        dshift;
  logic [W-1:0]       dec_v;

  always_comb begin
    span_c = in_span_q;
    if (span_c < lo_b) span_c = lo_b;
    if (span_c > hi_b) span_c = hi_b;
  end

  assign dsize  = in_side_q.prev[31:24];
  assign mant   = {9'b0, in_side_q.prev[22:0]};
  assign dshift = {dsize, 3'b000} - 11'd24;

  always_comb begin
    if (dsize <= 8'd3) begin
      dec_v = {{(W-32){1'b0}}, mant >> (5'd24 - {dsize[1:0], 3'b000})};
    end else if (dshift >= 11'(W)) begin
      dec_v = '0;
    end else begin
      dec_v = {{(W-32){1'b0}}, mant} << dshift;
    end
  end

  logic           mul_valid [0:32];
  drc_pkg::side_t mul_side  [0:32];
  logic [W-1:0]   mul_v     [0:32];
  logic [31:0]    mul_s     [0:32];
  logic [W-1:0]   mul_acc   [0:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid[0] <= 1'b0;
    end else if (en) begin
      mul_valid[0] <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_side[0] <= in_side_q;
      mul_v[0]    <= dec_v;
      mul_s[0]    <= span_c[31:0];
      mul_acc[0]  <= '0;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_mul
    drc_mul_cell #(.W(W), .K(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (mul_valid[k]),
      .side_i  (mul_side[k]),
      .v_i     (mul_v[k]),
      .s_i     (mul_s[k]),
      .acc_i   (mul_acc[k]),
      .valid_o (mul_valid[k+1]),
      .side_o  (mul_side[k+1]),
      .v_o     (mul_v[k+1]),
      .s_o     (mul_s[k+1]),
      .acc_o   (mul_acc[k+1])
    );
  end

  logic           div_valid [0:W];
  drc_pkg::side_t div_side  [0:W];
  logic [W-1:0]   div_num   [0:W];
  logic [30:0]    div_rem   [0:W];

  assign div_valid[0] = mul_valid[32];
  assign div_side[0]  = mul_side[32];
  assign div_num[0]   = mul_acc[32];
  assign div_rem[0]   = '0;

  for (genvar j = 0; j < W; j++) begin : g_div
    drc_div_cell #(.W(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .d_i     (avg_q),
      .valid_i (div_valid[j]),
      .side_i  (div_side[j]),
      .num_i   (div_num[j]),
      .rem_i   (div_rem[j]),
      .valid_o (div_valid[j+1]),
      .side_o  (div_side[j+1]),
      .num_o   (div_num[j+1]),
      .rem_o   (div_rem[j+1])
    );
  end

  // cap
  logic [255:0]   lim_full;
  logic [W-1:0]   lim;
  logic           cap_valid_q;
  drc_pkg::side_t cap_side_q;
  logic [W-1:0]   cap_v_q;

  assign lim_full = {lim3_q, lim2_q, lim1_q, lim0_q};
  assign lim      = lim_full[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
    end else if (en) begin
      cap_valid_q <= div_valid[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cap_side_q <= div_side[W];
      cap_v_q    <= (div_num[W] > lim) ? lim : div_num[W];
    end
  end

  // encode
  logic [PW-1:0] pad_v;
  logic [7:0]    esize;
  logic [7:0]    esize_fix;
  logic [31:0]   ew;
  logic [PW-1:0] eshr;
  logic [31:0]   enc;

  assign pad_v = {{(PW-W){1'b0}}, cap_v_q};

  always_comb begin
    esize = '0;
    for (int b = 0; b < NB; b++) begin
      if (pad_v[b*8 +: 8] != 8'h00) esize = 8'(b + 1);
    end
  end

  assign eshr = pad_v >> {esize - 8'd3, 3'b000};

  always_comb begin
    if (esize <= 8'd3) begin
      ew = cap_v_q[31:0] << (5'd24 - {esize[1:0], 3'b000});
    end else begin
      ew = eshr[31:0];
    end
    esize_fix = esize;
    if (ew[23]) begin
      ew        = ew >> 8;
      esize_fix = esize + 8'd1;
    end
    enc = {esize_fix, ew[23:0]};
  end

  logic        out_valid_q;
  logic [31:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= cap_side_q.bypass ? cap_side_q.prev : enc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `DRC_CHECK(a_cfg_starts_bounds, cfg_hit |=> busy, "bound update not started")
  `DRC_CHECK_ALWAYS(a_bounds_order, !busy |-> lo_b <= hi_b, "span bounds out of order")
  `DRC_CHECK(a_frozen_chain, !en |=> $stable(in_valid_q) && $stable(cap_valid_q),
             "cell chain moved while stalled")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams previous compact targets and measured spans into the retarget block
// under several register settings and checks every new compact target against
// a 256-bit arithmetic predictor, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
class retarget_scoreboard;
  bit          no_retarget;
  logic [30:0] avg_span;
  logic [6:0]  adj_up;
  logic [9:0]  adj_down;
  logic [255:0] pow_limit;
  logic [31:0] pending[$];
  int          errors;

  function new();
    no_retarget = 1'b0;
    avg_span    = drc_pkg::AVG_SPAN_RST;
    adj_up      = drc_pkg::ADJ_UP_RST;
    adj_down    = drc_pkg::ADJ_DOWN_RST;
    pow_limit   = {drc_pkg::LIMIT3_RST, {3{drc_pkg::LIMIT_RST}}};
    errors      = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      drc_pkg::REG_NO_RETARGET: no_retarget = val[0];
      drc_pkg::REG_AVG_SPAN:    avg_span = val[30:0];
      drc_pkg::REG_ADJ_UP:      adj_up = val[6:0];
      drc_pkg::REG_ADJ_DOWN:    adj_down = val[9:0];
      drc_pkg::REG_LIMIT3:      pow_limit[255:192] = val;
      drc_pkg::REG_LIMIT2:      pow_limit[191:128] = val;
      drc_pkg::REG_LIMIT1:      pow_limit[127:64] = val;
      default:                  pow_limit[63:0] = val;
    endcase
  endfunction

  function logic [31:0] retarget(logic [31:0] prev, logic [63:0] raw);
    longint       span, lo, hi, t;
    logic [255:0] v;
    logic [287:0] prod;
    int unsigned  sz, nbits;
    logic [31:0]  c;
    if (no_retarget) return prev;
    span = raw;
    t = longint'(avg_span);
    lo = t * (100 - longint'(adj_up)) / 100;
    hi = t * (100 + longint'(adj_down)) / 100;
    if (span < lo) span = lo;
    if (span > hi) span = hi;
    sz = prev[31:24];
    v = 256'(prev[22:0]);
    if (sz <= 3) v = v >> (8 * (3 - sz));
    else v = v << (8 * (sz - 3));
    prod = 288'(v) * 288'(span[31:0]);
    v = prod[255:0];
    if (avg_span == 0) v = '1;
    else v = v / 256'(avg_span);
    if (v > pow_limit) v = pow_limit;
    nbits = 0;
    for (int b = 0; b < 256; b++) if (v[b]) nbits = b + 1;
    sz = (nbits + 7) / 8;
    if (sz <= 3) c = v[31:0] << (8 * (3 - sz));
    else c = 32'(v >> (8 * (sz - 3)));
    if (c[23]) begin
      c = c >> 8;
      sz++;
    end
    return {sz[7:0], c[23:0]};
  endfunction

  function void note_input(logic [95:0] d);
    pending.push_back(retarget(d[31:0], d[95:32]));
  endfunction

  function void check_result(logic [31:0] got);
    logic [31:0] want;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("unexpected next_compact %h", got));
      return;
    end
    want = pending.pop_front();
    if (got !== want) report_mismatch($sformatf("next_compact %h, want %h", got, want));
  endfunction

  function void report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endfunction
endclass

module tb_top;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [95:0] s_axis_tdata;   // prev_compact, measured_span
  logic [31:0] m_axis_tdata;   // next_compact
  logic        cfg_we_i;
  logic [drc_pkg::IdxW-1:0] cfg_idx_i;
  logic [63:0] cfg_data_i;

  retarget_scoreboard sb;
  int  idle_cycles;
  int  hold_cycles;
  bit  stall_mode;

  difficulty_retarget_compact DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // sink: random stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_mode) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic send(logic [31:0] prev, logic [63:0] span);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {span, prev};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic pause();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_compact();
    logic [31:0] c = $urandom;
    if ($urandom_range(0, 3) != 0) c[31:24] = 8'($urandom_range(0, 34));
    return c;
  endfunction

  function automatic logic [63:0] rand_span(logic [30:0] t);
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'(-longint'($urandom_range(0, 5000)));
      default: return 64'(longint'(t) * $urandom_range(50, 150) / 100);
    endcase
  endfunction

  task automatic random_phase(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) pause();
      end
      burst--;
      send(rand_compact(), rand_span(sb.avg_span));
    end
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    idle_cycles = 0;
    hold_cycles = 0;
    stall_mode = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (50) @(posedge clk_i);

    send(32'h1d00ffff, 64'd3000);
    send(32'h1d00ffff, 64'h7FFF_FFFF_FFFF_FFFF);
    send(32'h1d00ffff, 64'h8000_0000_0000_0000);
    send(32'h0, 64'd0);
    send(32'hFFFF_FFFF, 64'd3100);
    send(32'h0100_0080, 64'd3000);
    send(32'h0312_3456, 64'd2000);
    send(32'h0280_FFFF, 64'd3000);
    send(32'h2200_FFFF, 64'd3480);
    send(32'h2100_7FFF, 64'd2880);
    send(32'h1b7F_FFFF, 64'd3200);
    send(32'h1c80_0001, 64'd2900);
    pause();
    hold_cycles <= 600;
    for (int i = 0; i < 300; i++) send(rand_compact(), rand_span(3000));
    s_axis_tvalid <= 1'b0;
    drain();

    write_reg(drc_pkg::REG_NO_RETARGET, 64'd1);
    random_phase(100);
    write_reg(drc_pkg::REG_NO_RETARGET, 64'd0);
    write_reg(drc_pkg::REG_ADJ_UP, 64'd100);
    write_reg(drc_pkg::REG_ADJ_DOWN, 64'd1000);
    write_reg(drc_pkg::REG_AVG_SPAN, 64'h7FFF_FFFF);
    send(32'h1d00ffff, 64'h7FFF_FFFF_FFFF_FFFF);
    send(32'h1d00ffff, 64'h8000_0000_0000_0000);
    random_phase(250);
    write_reg(drc_pkg::REG_ADJ_UP, 64'd127);
    write_reg(drc_pkg::REG_ADJ_DOWN, 64'd0);
    write_reg(drc_pkg::REG_AVG_SPAN, 64'd1);
    write_reg(drc_pkg::REG_LIMIT3, 64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(250);
    write_reg(drc_pkg::REG_AVG_SPAN, 64'd0);
    write_reg(drc_pkg::REG_LIMIT3, 64'd0);
    write_reg(drc_pkg::REG_LIMIT2, 64'h0000_0000_FFFF_0000);
    write_reg(drc_pkg::REG_LIMIT1, 64'h1234_5678_9ABC_DEF0);
    write_reg(drc_pkg::REG_LIMIT0, 64'd0);
    random_phase(150);
    write_reg(drc_pkg::REG_AVG_SPAN, 64'd600);
    write_reg(drc_pkg::REG_ADJ_UP, 64'd25);
    write_reg(drc_pkg::REG_ADJ_DOWN, 64'd300);
    write_reg(drc_pkg::REG_LIMIT2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(drc_pkg::REG_LIMIT1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(drc_pkg::REG_LIMIT0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(drc_pkg::REG_LIMIT3, 64'h0000_0FFF_FFFF_FFFF);
    random_phase(450);

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/drc_pkg.sv
sv/drc_mul_cell.sv
sv/drc_div_cell.sv
sv/drc_bounds.sv
sv/difficulty_retarget_compact.sv
tb/tb_top.sv
